// ===== src/bst_pkg.sv =====
package bst_pkg;

  localparam int MAX_SLOTS   = 16;
  localparam int COORD_W     = 12;
  localparam int SLOT_W      = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W       = $clog2(MAX_SLOTS + 1);
  localparam int CFG_SLOTS_W = 5;
  localparam int N_W         = (CNT_W > CFG_SLOTS_W) ? CNT_W : CFG_SLOTS_W;
  localparam int RADIUS_W    = 8;
  localparam int CAP_W       = 6;
  localparam int ENERGY_W    = 8;
  localparam int IDX_OUT_W   = 4;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int R2_W        = 2 * RADIUS_W;
  localparam int D2_W        = 2 * COORD_W + 1;

  localparam logic [STATUS_W-1:0] ST_TICK  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MATCH = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CLAIM = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DROP  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SLOTS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAP    = 2'd2;

  localparam logic [CFG_SLOTS_W-1:0] RST_SLOTS  = 5'd16;
  localparam logic [RADIUS_W-1:0]    RST_RADIUS = 8'd5;
  localparam logic [CAP_W-1:0]       RST_CAP    = 6'd20;

  localparam logic signed [ENERGY_W-1:0] ENERGY_GAIN  = 8'sd2;
  localparam logic signed [ENERGY_W-1:0] ENERGY_DECAY = 8'sd1;

  typedef struct packed {
    logic start;
    logic tick_step;
    logic det_step;
    logic claim;
    logic load_out;
  } bst_cmd_t;

  typedef struct packed {
    logic empty;
    logic last;
    logic hit;
    logic out_free;
  } bst_stat_t;

endpackage

// ===== src/bst_req_if.sv =====
interface bst_req_if import bst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [COORD_W-1:0] det_x;
  logic [COORD_W-1:0] det_y;

  modport source (output valid, req_type, det_x, det_y, input ready);
  modport sink (input valid, req_type, det_x, det_y, output ready);
endinterface

// ===== src/bst_rsp_if.sv =====
interface bst_rsp_if import bst_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [STATUS_W-1:0]         status;
  logic [IDX_OUT_W-1:0]        slot_index;
  logic signed [ENERGY_W-1:0]  slot_energy;

  modport source (output valid, status, slot_index, slot_energy, input ready);
  modport sink (input valid, status, slot_index, slot_energy, output ready);
endinterface

// ===== src/bst_cfg_if.sv =====
interface bst_cfg_if import bst_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/bst_ctrl.sv =====
module bst_ctrl import bst_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  input  logic      req_type,
  output logic      req_ready,
  input  bst_stat_t stat,
  output bst_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TICK  = 3'd1;
  localparam logic [2:0] S_DET   = 3'd2;
  localparam logic [2:0] S_CLAIM = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    cmd        = '0;
    req_ready  = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.start = 1'b1;
          if (stat.empty) begin
            state_next = S_FIN;
          end else if (req_type) begin
            state_next = S_DET;
          end else begin
            state_next = S_TICK;
          end
        end
      end
      S_TICK: begin
        cmd.tick_step = 1'b1;
        if (stat.last) begin
          state_next = S_FIN;
        end
      end
      S_DET: begin
        cmd.det_step = 1'b1;
        if (stat.hit) begin
          state_next = S_FIN;
        end else if (stat.last) begin
          state_next = S_CLAIM;
        end
      end
      S_CLAIM: begin
        cmd.claim  = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/bst_dp.sv =====
module bst_dp import bst_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       req_type,
  input  logic [COORD_W-1:0]         det_x,
  input  logic [COORD_W-1:0]         det_y,
  input  bst_cmd_t                   cmd,
  output bst_stat_t                  stat,
  input  logic                       rsp_ready,
  output logic                       rsp_valid,
  output logic [STATUS_W-1:0]        rsp_status,
  output logic [IDX_OUT_W-1:0]       rsp_slot_index,
  output logic signed [ENERGY_W-1:0] rsp_slot_energy
);

  logic [CFG_SLOTS_W-1:0] slots_in_use;
  logic [RADIUS_W-1:0]    match_radius;
  logic [CAP_W-1:0]       energy_cap_halves;

  logic [MAX_SLOTS-1:0]       slot_active;
  logic [COORD_W-1:0]         slot_x [MAX_SLOTS];
  logic [COORD_W-1:0]         slot_y [MAX_SLOTS];
  logic signed [ENERGY_W-1:0] slot_energy [MAX_SLOTS];

  logic [SLOT_W-1:0]          idx;
  logic [SLOT_W-1:0]          free_idx;
  logic                       free_found;
  logic [COORD_W-1:0]         cur_x;
  logic [COORD_W-1:0]         cur_y;
  logic [R2_W-1:0]            r2;
  logic [STATUS_W-1:0]        res_status;
  logic [SLOT_W-1:0]          res_idx;
  logic signed [ENERGY_W-1:0] res_energy;

  logic [N_W-1:0]             n;
  logic                       last;
  logic                       cur_active;
  logic signed [ENERGY_W-1:0] cur_energy;
  logic [COORD_W:0]           dx_s;
  logic [COORD_W:0]           dy_s;
  logic [COORD_W-1:0]         adx;
  logic [COORD_W-1:0]         ady;
  logic [2*COORD_W-1:0]       dx2;
  logic [2*COORD_W-1:0]       dy2;
  logic [D2_W-1:0]            d2;
  logic                       hit;
  logic signed [ENERGY_W-1:0] cap_s;
  logic signed [ENERGY_W-1:0] hit_energy;
  logic signed [ENERGY_W-1:0] claim_energy;
  logic                       decay_kill;

  assign n = (N_W'(slots_in_use) > N_W'(MAX_SLOTS)) ? N_W'(MAX_SLOTS) : N_W'(slots_in_use);
  assign last = (N_W'(idx) + N_W'(1)) == n;

  assign cur_active = slot_active[idx];
  assign cur_energy = slot_energy[idx];

  assign dx_s = {1'b0, cur_x} - {1'b0, slot_x[idx]};
  assign dy_s = {1'b0, cur_y} - {1'b0, slot_y[idx]};
  assign adx  = dx_s[COORD_W] ? COORD_W'(-dx_s) : dx_s[COORD_W-1:0];
  assign ady  = dy_s[COORD_W] ? COORD_W'(-dy_s) : dy_s[COORD_W-1:0];
  assign dx2  = (2*COORD_W)'(adx) * (2*COORD_W)'(adx);
  assign dy2  = (2*COORD_W)'(ady) * (2*COORD_W)'(ady);
  assign d2   = D2_W'(dx2) + D2_W'(dy2);
  assign hit  = cur_active && (d2 < D2_W'(r2));

  assign cap_s        = $signed({{(ENERGY_W-CAP_W){1'b0}}, energy_cap_halves});
  assign hit_energy   = (cur_energy < cap_s) ? cur_energy + ENERGY_GAIN : cur_energy;
  assign claim_energy = (cap_s > 0) ? ENERGY_GAIN : '0;
  assign decay_kill   = cur_energy < 0;

  assign stat.empty    = (n == '0);
  assign stat.last     = last;
  assign stat.hit      = hit;
  assign stat.out_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use      <= RST_SLOTS;
      match_radius      <= RST_RADIUS;
      energy_cap_halves <= RST_CAP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SLOTS:  slots_in_use      <= cfg_data[CFG_SLOTS_W-1:0];
        REG_RADIUS: match_radius      <= cfg_data[RADIUS_W-1:0];
        REG_CAP:    energy_cap_halves <= cfg_data[CAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_active <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_SLOTS) begin
        slot_active <= '0;
      end
      if (cmd.tick_step && cur_active && decay_kill) begin
        slot_active[idx] <= 1'b0;
      end
      if (cmd.claim && free_found) begin
        slot_active[free_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_step && cur_active) begin
      slot_energy[idx] <= decay_kill ? '0 : cur_energy - ENERGY_DECAY;
    end
    if (cmd.det_step && hit) begin
      slot_x[idx]      <= cur_x;
      slot_y[idx]      <= cur_y;
      slot_energy[idx] <= hit_energy;
    end
    if (cmd.claim && free_found) begin
      slot_x[free_idx]      <= cur_x;
      slot_y[free_idx]      <= cur_y;
      slot_energy[free_idx] <= claim_energy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_found <= 1'b0;
    end else if (cmd.start) begin
      free_found <= 1'b0;
    end else if (cmd.det_step && !hit && !cur_active && !free_found) begin
      free_found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      idx        <= '0;
      cur_x      <= det_x;
      cur_y      <= det_y;
      r2         <= R2_W'(match_radius) * R2_W'(match_radius);
      res_status <= req_type ? ST_DROP : ST_TICK;
      res_idx    <= '0;
      res_energy <= '0;
    end
    if (cmd.tick_step && !last) begin
      idx <= idx + SLOT_W'(1);
    end
    if (cmd.det_step) begin
      if (hit) begin
        res_status <= ST_MATCH;
        res_idx    <= idx;
        res_energy <= hit_energy;
      end else begin
        if (!cur_active && !free_found) begin
          free_idx <= idx;
        end
        if (!last) begin
          idx <= idx + SLOT_W'(1);
        end
      end
    end
    if (cmd.claim && free_found) begin
      res_status <= ST_CLAIM;
      res_idx    <= free_idx;
      res_energy <= claim_energy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp_status      <= res_status;
      rsp_slot_index  <= IDX_OUT_W'(res_idx);
      rsp_slot_energy <= res_energy;
    end
  end

endmodule

// ===== src/blob_slot_tracker.sv =====
// Tracks up to sixteen blobs; a detection matches the lowest-numbered active slot whose center
// lies within the radius, and energies decay on ticks. Each request is a frame tick or a
// detection, and each gives exactly one response. The datapath examines one slot per cycle
// with a single distance unit, so with N the number of slots in use (capped at sixteen), a tick
// visits all N slots, a detection that hits slot i stops there, and a detection that claims a
// slot or is dropped visits all N slots and then a claim step; with no slot in use the search is skipped.
// The block takes one request at a time; a new request is accepted as soon as the previous
// response sits in the output register, even while that response still waits to be taken.
// Writing the slot count clears the whole table; configuration writes are always accepted.
module blob_slot_tracker import bst_pkg::*; (
  input logic      clk,
  input logic      rst,
  bst_req_if.sink   req,
  bst_rsp_if.source rsp,
  bst_cfg_if.sink   cfg
);

  bst_cmd_t  cmd;
  bst_stat_t stat;

  assign cfg.ready = 1'b1;

  bst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_type  (req.req_type),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bst_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg.valid),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .req_type        (req.req_type),
    .det_x           (req.det_x),
    .det_y           (req.det_y),
    .cmd             (cmd),
    .stat            (stat),
    .rsp_ready       (rsp.ready),
    .rsp_valid       (rsp.valid),
    .rsp_status      (rsp.status),
    .rsp_slot_index  (rsp.slot_index),
    .rsp_slot_energy (rsp.slot_energy)
  );

endmodule

// ===== src/bst_checker.sv =====
module bst_checker import bst_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [STATUS_W-1:0]        rsp_status,
  input logic [IDX_OUT_W-1:0]       rsp_slot_index,
  input logic signed [ENERGY_W-1:0] rsp_slot_energy
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("Response dropped before its transaction completed.");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_slot_index)
      && $stable(rsp_slot_energy))
    else $error("Stalled response payload changed.");

  a_idle_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == ST_TICK || rsp_status == ST_DROP)
      |-> rsp_slot_index == '0 && rsp_slot_energy == '0)
    else $error("Tick or dropped response carries a slot or an energy.");

  a_claim_energy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_CLAIM
      |-> rsp_slot_energy == '0 || rsp_slot_energy == ENERGY_GAIN)
    else $error("Newly claimed slot reports an impossible energy.");

endmodule

bind blob_slot_tracker bst_checker u_bst_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_slot_index  (rsp.slot_index),
  .rsp_slot_energy (rsp.slot_energy)
);

// ===== bench/blob_slot_tracker_test.sv =====
`timescale 1ns / 100ps

module blob_slot_tracker_test;
  import bst_pkg::*;

  localparam bit REQ_TICK   = 1'b0;
  localparam bit REQ_DETECT = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [COORD_W-1:0] COORD_MAX = '1;

  typedef struct {
    logic [STATUS_W-1:0]        status;
    logic [IDX_OUT_W-1:0]       slot_index;
    logic signed [ENERGY_W-1:0] slot_energy;
  } track_report_t;

  class blob_track_board;
    bit            live_mark[MAX_SLOTS];
    int            center_x[MAX_SLOTS];
    int            center_y[MAX_SLOTS];
    int            energy[MAX_SLOTS];
    int unsigned   slot_count;
    int unsigned   radius;
    int unsigned   cap;
    track_report_t predicted[$];
    int            mismatches;
    int            status_seen[4];
    int            peak_energy;

    function new();
      slot_count = int'(RST_SLOTS);
      radius = int'(RST_RADIUS);
      cap = int'(RST_CAP);
      mismatches = 0;
      peak_energy = 0;
      foreach (status_seen[s]) status_seen[s] = 0;
      clear_slots();
    endfunction

    function void clear_slots();
      foreach (live_mark[i]) begin
        live_mark[i] = 1'b0;
        center_x[i] = 0;
        center_y[i] = 0;
        energy[i] = 0;
      end
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_SLOTS: begin
          slot_count = int'(value & 8'h1F);
          clear_slots();
        end
        REG_RADIUS: radius = int'(value);
        REG_CAP: cap = int'(value & 8'h3F);
        default: ;
      endcase
    endfunction

    function void add_charge(int i);
      if (energy[i] < int'(cap)) energy[i] += 2;
    endfunction

    function void note_request(bit kind, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      track_report_t rep;
      int            n;
      int            i;
      longint        dx;
      longint        dy;
      longint        r2;
      bit            done;
      n = (slot_count > MAX_SLOTS) ? MAX_SLOTS : slot_count;
      rep.status = ST_TICK;
      rep.slot_index = '0;
      rep.slot_energy = '0;
      if (kind == REQ_TICK) begin
        for (i = 0; i < n; i++) begin
          if (live_mark[i] && energy[i] < 0) begin
            live_mark[i] = 1'b0;
            energy[i] = 0;
            center_x[i] = 0;
            center_y[i] = 0;
          end
          if (live_mark[i]) energy[i] -= 1;
        end
      end else begin
        r2 = longint'(radius) * longint'(radius);
        done = 1'b0;
        rep.status = ST_DROP;
        for (i = 0; i < n && !done; i++) begin
          if (live_mark[i]) begin
            dx = longint'(x) - longint'(center_x[i]);
            dy = longint'(y) - longint'(center_y[i]);
            if (dx * dx + dy * dy < r2) begin
              center_x[i] = x;
              center_y[i] = y;
              add_charge(i);
              rep.status = ST_MATCH;
              rep.slot_index = IDX_OUT_W'(i);
              rep.slot_energy = ENERGY_W'(energy[i]);
              done = 1'b1;
            end
          end
        end
        for (i = 0; i < n && !done; i++) begin
          if (!live_mark[i]) begin
            center_x[i] = x;
            center_y[i] = y;
            live_mark[i] = 1'b1;
            add_charge(i);
            rep.status = ST_CLAIM;
            rep.slot_index = IDX_OUT_W'(i);
            rep.slot_energy = ENERGY_W'(energy[i]);
            done = 1'b1;
          end
        end
      end
      predicted = {predicted, rep};
    endfunction

    function void check_report(logic [STATUS_W-1:0] st, logic [IDX_OUT_W-1:0] idx,
                               logic signed [ENERGY_W-1:0] en);
      track_report_t want;
      if (predicted.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result status %0d slot %0d energy %0d",
                   $realtime, st, idx, en);
      end else begin
        want = predicted.pop_front();
        status_seen[st]++;
        if (en > peak_energy) peak_energy = en;
        if (st !== want.status || idx !== want.slot_index || en !== want.slot_energy) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: expected status %0d slot %0d energy %0d, got %0d %0d %0d",
                     $realtime, want.status, want.slot_index, want.slot_energy,
                     st, idx, en);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   gaps_on = 1'b1;
  int   hold_request = 0;
  int   requests_sent = 0;
  int   reg_writes = 0;
  blob_track_board board = new();

  bst_req_if req_ch ();
  bst_rsp_if rsp_ch ();
  bst_cfg_if cfg_ch ();

  blob_slot_tracker dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!gaps_on || roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [COORD_W-1:0] clamp_coord(int v);
    if (v < 0) return '0;
    if (v > int'(COORD_MAX)) return COORD_MAX;
    return COORD_W'(v);
  endfunction

  task automatic send_request(bit kind, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.det_x <= x;
    req_ch.det_y <= y;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    board.note_request(kind, x, y);
    requests_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    board.write_register(idx, value);
    reg_writes++;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_pending();
    req_ch.valid <= 1'b0;
    while (board.predicted.size() != 0) @(posedge clk);
  endtask

  task automatic offer_random(int tick_pct, int near_pct);
    int                 roll;
    int                 i;
    int                 pick;
    int                 jitter_x;
    int                 jitter_y;
    int                 busy[$];
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    roll = $urandom_range(0, 99);
    x = COORD_W'($urandom);
    y = COORD_W'($urandom);
    if (roll >= tick_pct && roll < tick_pct + near_pct) begin
      for (i = 0; i < MAX_SLOTS; i++)
        if (board.live_mark[i]) busy = {busy, i};
      if (busy.size() != 0) begin
        pick = busy[$urandom_range(0, busy.size() - 1)];
        jitter_x = $urandom_range(0, 2 * board.radius);
        jitter_y = $urandom_range(0, 2 * board.radius);
        x = clamp_coord(board.center_x[pick] + jitter_x - int'(board.radius));
        y = clamp_coord(board.center_y[pick] + jitter_y - int'(board.radius));
      end
    end
    send_request((roll < tick_pct) ? REQ_TICK : REQ_DETECT, x, y);
  endtask

  task automatic run_phase(logic [7:0] slots_val, logic [7:0] radius_val, logic [7:0] cap_val,
                           int count, bit gaps, int tick_pct, int near_pct,
                           int hold_cycles, bit mid_pause);
    int k;
    drain_pending();
    write_reg(REG_SLOTS, slots_val);
    write_reg(REG_RADIUS, radius_val);
    write_reg(REG_CAP, cap_val);
    gaps_on = gaps;
    for (k = 0; k < count; k++) begin
      if (k == count / 2) begin
        if (hold_cycles != 0) hold_request = hold_cycles;
        if (mid_pause) drain_pending();
      end
      offer_random(tick_pct, near_pct);
    end
  endtask

  initial begin : result_side
    int stall;
    stall = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        board.check_report(rsp_ch.status, rsp_ch.slot_index, rsp_ch.slot_energy);
        stall = pick_gap();
      end else if (rsp_ch.valid !== 1'b1 && $urandom_range(0, 9) == 0) begin
        stall = pick_gap();
      end
      if (hold_request != 0) begin
        stall = hold_request;
        hold_request = 0;
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        stall--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.req_type <= REQ_TICK;
    req_ch.det_x <= '0;
    req_ch.det_y <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_SLOTS;
    cfg_ch.data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: the radius boundary, index order and decay down to clearing.
    send_request(REQ_TICK, 0, 0);
    send_request(REQ_DETECT, 0, 0);
    send_request(REQ_DETECT, COORD_MAX, COORD_MAX);
    send_request(REQ_DETECT, 3, 4);
    send_request(REQ_DETECT, 2, 4);
    send_request(REQ_DETECT, COORD_MAX, COORD_MAX - COORD_W'(1));
    repeat (4) send_request(REQ_TICK, COORD_MAX, COORD_MAX);
    send_request(REQ_DETECT, 2048, 2048);
    send_request(REQ_DETECT, 0, 0);

    // One slot and an energy cap of zero, then a hit on a slot whose energy went negative.
    drain_pending();
    write_reg(REG_SLOTS, 8'd1);
    write_reg(REG_CAP, 8'd0);
    send_request(REQ_DETECT, 100, 100);
    send_request(REQ_DETECT, 100, 100);
    send_request(REQ_DETECT, COORD_MAX, 0);
    send_request(REQ_TICK, 0, 0);
    send_request(REQ_DETECT, 101, 100);

    drain_pending();
    write_reg(REG_SLOTS, 8'd0);
    write_reg(REG_RADIUS, 8'hFF);
    send_request(REQ_DETECT, 0, COORD_MAX);
    send_request(REQ_TICK, 0, 0);

    drain_pending();
    write_reg(REG_UNUSED, 8'hAA);
    write_reg(REG_SLOTS, 8'hFF);
    write_reg(REG_RADIUS, 8'd0);
    write_reg(REG_CAP, 8'hFF);
    send_request(REQ_DETECT, 7, 7);
    send_request(REQ_DETECT, 7, 7);
    send_request(REQ_TICK, 0, 0);

    run_phase(8'd16, 8'd5, 8'd20, 110, 1'b1, 20, 65, 250, 1'b0);
    run_phase(8'd4, 8'd40, 8'hFF, 100, 1'b1, 15, 70, 0, 1'b1);
    run_phase(8'd1, 8'd255, 8'd10, 50, 1'b0, 25, 50, 0, 1'b0);
    run_phase(8'd2, 8'd255, 8'd63, 80, 1'b1, 4, 90, 0, 1'b0);
    run_phase(8'd0, 8'd100, 8'd30, 20, 1'b1, 30, 50, 0, 1'b0);
    run_phase(8'h3F, 8'd0, 8'd0, 60, 1'b1, 20, 60, 0, 1'b0);
    run_phase(8'd16, 8'd255, 8'd20, 100, 1'b0, 15, 60, 300, 1'b0);
    run_phase(8'd8, 8'd12, 8'd5, 150, 1'b1, 20, 65, 0, 1'b1);

    drain_pending();
    repeat (24) @(posedge clk);

    if (board.predicted.size() != 0)
      $display("%0d expected results never arrived", board.predicted.size());
    $display("Sent %0d requests and %0d register writes across twelve table settings.",
             requests_sent, reg_writes);
    $display("Seen %0d ticks, %0d matches, %0d claims, %0d drops; peak energy %0d half units.",
             board.status_seen[ST_TICK], board.status_seen[ST_MATCH],
             board.status_seen[ST_CLAIM], board.status_seen[ST_DROP], board.peak_energy);
    if (board.mismatches == 0 && board.predicted.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/bst_pkg.sv
src/bst_req_if.sv
src/bst_rsp_if.sv
src/bst_cfg_if.sv
src/bst_ctrl.sv
src/bst_dp.sv
src/blob_slot_tracker.sv
src/bst_checker.sv
bench/blob_slot_tracker_test.sv
